// ===== sv/rrps_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rrps_pkg
// Shared codes and types of the round-robin process scheduler.
// ----------------------------------------------------------------------------
package rrps_pkg;
    localparam logic [3:0] MODE_CREATE   = 4'd0;
    localparam logic [3:0] MODE_BLOCK    = 4'd1;
    localparam logic [3:0] MODE_UNBLOCK  = 4'd2;
    localparam logic [3:0] MODE_WAKE     = 4'd3;
    localparam logic [3:0] MODE_DISPATCH = 4'd4;
    localparam logic [3:0] MODE_WAIT     = 4'd5;
    localparam logic [3:0] MODE_EXIT     = 4'd6;
    localparam logic [3:0] MODE_LOCK     = 4'd7;
    localparam logic [3:0] MODE_UNLOCK   = 4'd8;

    localparam logic [2:0] R_RUN      = 3'd0;
    localparam logic [2:0] R_DEADLINE = 3'd1;
    localparam logic [2:0] R_CONSOLE  = 3'd2;
    localparam logic [2:0] R_LOCK     = 3'd3;

    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_BUSY = 2'd2;

    // Result of the per-slot wait check.
    typedef struct packed {
        logic expired;
        logic console_hit;
    } chk_t;
endpackage
`default_nettype wire

// ===== sv/rrps_check.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rrps_check
// Shared wait-release unit: deadline subtract and console bit test for one slot.
// ----------------------------------------------------------------------------
module rrps_check #(
    parameter int NUM_CONSOLES = 16
) (
    input  wire logic [31:0]           now_tick,
    input  wire logic [31:0]           slot_deadline,
    input  wire logic [7:0]            slot_object,
    input  wire logic [15:0]           console_ready,
    output rrps_pkg::chk_t             chk
);
    logic [31:0] diff;

    assign diff = now_tick - slot_deadline;

    // A console number at or above NUM_CONSOLES is never ready.
    always_comb begin
        chk.expired     = ~diff[31];
        chk.console_hit = (slot_object < 8'(NUM_CONSOLES))
                          && console_ready[slot_object[3:0]];
    end
endmodule
`default_nettype wire

// ===== sv/round_robin_process_scheduler.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// round_robin_process_scheduler
// Process-slot scheduler with blocking waits and a recursive owner lock.
// ----------------------------------------------------------------------------
// Each request beat is handled by a small sequencer that walks the slot table
// one slot per cycle through a single shared compare unit. Create, block,
// unblock, uncontended lock, wake for R_RUN, unlock that keeps the lock, an
// unused mode, and dispatch, wait or lock-keeping exit with under two live
// slots go straight to the result. Other wakes and lock-freeing unlocks make
// a wake pass; a lock-keeping exit a pick pass; dispatch, wait and contended
// lock a scan pass and a pick pass; a lock-dropping exit a wake pass, then a
// pick pass with two or more live slots. The result beat sits in an output
// register, held while m_tready is low; the next request is taken once it
// has been delivered. base_slice of zero is reported as one.
module round_robin_process_scheduler #(
    parameter int NUM_SLOTS    = 4,
    parameter int NUM_CONSOLES = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_wdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // mode[3:0], reason[6:4], wait_object[14:7], deadline[46:15],
    // now_tick[78:47], console_ready[94:79], zero fill
    input  wire logic [95:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // status[1:0], running_slot[3:2], switched[4], new_slot[6:5],
    // live_count[9:7], lock_held[10], slice_ticks[26:11], zero fill
    output logic [31:0]      m_tdata
);
    localparam int SW = $clog2(NUM_SLOTS);
    localparam int CW = $clog2(NUM_SLOTS + 1);
    localparam logic [SW-1:0] LAST = SW'(NUM_SLOTS - 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_PICK   = 3'd2;
    localparam logic [2:0] S_WAKE   = 3'd3;
    localparam logic [2:0] S_FIN    = 3'd4;
    localparam logic [2:0] S_OUT    = 3'd5;
    localparam logic [2:0] S_COMMIT = 3'd6;

    logic [2:0]  state_reg;
    logic [15:0] slice_reg;
    logic [NUM_SLOTS-1:0] live_reg;
    logic [2:0]  reason_reg   [NUM_SLOTS];
    logic [7:0]  object_reg   [NUM_SLOTS];
    logic [31:0] deadline_reg [NUM_SLOTS];
    logic [SW-1:0] cur_reg, owner_reg, idx_reg, cnt_reg, nxt_reg;
    logic [CW-1:0] live_total_reg;
    logic [7:0]  depth_reg;
    logic [95:0] in_reg;
    logic [1:0]  status_reg;
    logic        sw_reg, found_reg, need_run_reg;
    logic [SW-1:0] new_reg;
    logic [31:0] m_tdata_reg;

    logic [3:0]  mode;
    logic [2:0]  reason;
    logic [7:0]  wobj;
    logic [31:0] wdl, now_tick;
    logic [15:0] ready;
    assign mode     = in_reg[3:0];
    assign reason   = in_reg[6:4];
    assign wobj     = in_reg[14:7];
    assign wdl      = in_reg[46:15];
    assign now_tick = in_reg[78:47];
    assign ready    = in_reg[94:79];

    // Exit and unlock only ever wake the lock waiters.
    logic [2:0] wake_reason;
    logic [7:0] wake_obj;
    assign wake_reason = (mode == rrps_pkg::MODE_WAKE) ? reason : rrps_pkg::R_LOCK;
    assign wake_obj    = (mode == rrps_pkg::MODE_WAKE) ? wobj : 8'd0;

    rrps_pkg::chk_t chk;
    rrps_check #(.NUM_CONSOLES(NUM_CONSOLES)) u_check (
        .now_tick     (now_tick),
        .slot_deadline(deadline_reg[idx_reg]),
        .slot_object  (object_reg[idx_reg]),
        .console_ready(ready),
        .chk          (chk)
    );

    logic [SW-1:0] idx_inc, cur_inc, first_free;
    logic          any_free, lock_busy, drop_lock;
    assign idx_inc = (idx_reg == LAST) ? '0 : idx_reg + SW'(1);
    assign cur_inc = (cur_reg == LAST) ? '0 : cur_reg + SW'(1);
    assign lock_busy = (depth_reg != 8'd0) && (owner_reg != cur_reg)
                       && (live_total_reg >= CW'(2));
    assign drop_lock = (depth_reg != 8'd0) && (owner_reg == cur_reg);

    always_comb begin
        first_free = '0;
        any_free   = 1'b0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (!live_reg[i]) begin
                first_free = SW'(i);
                any_free   = 1'b1;
            end
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT);
    assign m_tdata  = m_tdata_reg;

    // Waiting count is implied by the table; reason updates keep it consistent.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            slice_reg      <= 16'd8;
            live_reg       <= NUM_SLOTS'(1);
            cur_reg        <= '0;
            owner_reg      <= '0;
            depth_reg      <= '0;
            live_total_reg <= CW'(1);
            for (int i = 0; i < NUM_SLOTS; i++) begin
                reason_reg[i]   <= rrps_pkg::R_RUN;
                object_reg[i]   <= '0;
                deadline_reg[i] <= '0;
            end
        end else begin
            if (cfg_we) begin
                slice_reg <= cfg_wdata;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        in_reg       <= s_tdata;
                        status_reg   <= (s_tdata[3:0] == rrps_pkg::MODE_CREATE && !any_free)
                                        ? rrps_pkg::ST_FULL
                                        : (s_tdata[3:0] == rrps_pkg::MODE_LOCK && lock_busy)
                                        ? rrps_pkg::ST_BUSY : rrps_pkg::ST_DONE;
                        new_reg      <= (s_tdata[3:0] == rrps_pkg::MODE_CREATE && any_free)
                                        ? first_free : '0;
                        sw_reg       <= 1'b0;
                        idx_reg      <= (s_tdata[3:0] == rrps_pkg::MODE_EXIT && !drop_lock)
                                        ? cur_inc : '0;
                        cnt_reg      <= '0;
                        found_reg    <= 1'b0;
                        need_run_reg <= 1'b0;
                        unique case (s_tdata[3:0])
                            rrps_pkg::MODE_CREATE: begin
                                if (any_free) begin
                                    live_reg[first_free]     <= 1'b1;
                                    reason_reg[first_free]   <= rrps_pkg::R_RUN;
                                    object_reg[first_free]   <= '0;
                                    deadline_reg[first_free] <= '0;
                                    live_total_reg <= live_total_reg + CW'(1);
                                end
                                state_reg <= S_FIN;
                            end
                            rrps_pkg::MODE_BLOCK: begin
                                reason_reg[cur_reg]   <= s_tdata[6:4];
                                object_reg[cur_reg]   <= s_tdata[14:7];
                                deadline_reg[cur_reg] <= s_tdata[46:15];
                                state_reg <= S_FIN;
                            end
                            rrps_pkg::MODE_UNBLOCK: begin
                                reason_reg[cur_reg] <= rrps_pkg::R_RUN;
                                state_reg <= S_FIN;
                            end
                            rrps_pkg::MODE_WAKE: begin
                                state_reg <= (s_tdata[6:4] != rrps_pkg::R_RUN)
                                             ? S_WAKE : S_FIN;
                            end
                            rrps_pkg::MODE_DISPATCH: begin
                                state_reg <= (live_total_reg >= CW'(2)) ? S_SCAN : S_FIN;
                            end
                            rrps_pkg::MODE_WAIT: begin
                                object_reg[cur_reg]   <= s_tdata[14:7];
                                deadline_reg[cur_reg] <= s_tdata[46:15];
                                if (live_total_reg >= CW'(2)) begin
                                    reason_reg[cur_reg] <= s_tdata[6:4];
                                    state_reg <= S_SCAN;
                                end else begin
                                    reason_reg[cur_reg] <= rrps_pkg::R_RUN;
                                    state_reg <= S_FIN;
                                end
                            end
                            rrps_pkg::MODE_EXIT: begin
                                if (drop_lock) begin
                                    depth_reg <= '0;
                                    owner_reg <= '0;
                                    state_reg <= S_WAKE;
                                end else if (live_total_reg >= CW'(2)) begin
                                    state_reg <= S_PICK;
                                end else begin
                                    state_reg <= S_FIN;
                                end
                            end
                            rrps_pkg::MODE_LOCK: begin
                                if (lock_busy) begin
                                    reason_reg[cur_reg]   <= rrps_pkg::R_LOCK;
                                    object_reg[cur_reg]   <= '0;
                                    deadline_reg[cur_reg] <= '0;
                                    state_reg <= S_SCAN;
                                end else begin
                                    owner_reg <= cur_reg;
                                    if (depth_reg != 8'hFF) begin
                                        depth_reg <= depth_reg + 8'd1;
                                    end
                                    state_reg <= S_FIN;
                                end
                            end
                            rrps_pkg::MODE_UNLOCK: begin
                                if (depth_reg <= 8'd1) begin
                                    depth_reg <= '0;
                                    owner_reg <= '0;
                                    state_reg <= S_WAKE;
                                end else begin
                                    depth_reg <= depth_reg - 8'd1;
                                    state_reg <= S_FIN;
                                end
                            end
                            default: state_reg <= S_FIN;
                        endcase
                    end
                end
                S_SCAN: begin
                    if (live_reg[idx_reg]) begin
                        if ((reason_reg[idx_reg] == rrps_pkg::R_DEADLINE && chk.expired)
                            || (reason_reg[idx_reg] == rrps_pkg::R_CONSOLE
                                && chk.console_hit)) begin
                            reason_reg[idx_reg] <= rrps_pkg::R_RUN;
                        end
                    end
                    if (idx_reg == LAST) begin
                        idx_reg      <= cur_inc;
                        need_run_reg <= 1'b1;
                        state_reg    <= S_PICK;
                    end else begin
                        idx_reg <= idx_inc;
                    end
                end
                S_PICK: begin
                    if (!found_reg && live_reg[idx_reg] && (!need_run_reg
                        || reason_reg[idx_reg] == rrps_pkg::R_RUN)) begin
                        found_reg <= 1'b1;
                        nxt_reg   <= idx_reg;
                    end
                    idx_reg <= idx_inc;
                    cnt_reg <= cnt_reg + SW'(1);
                    if (cnt_reg == LAST) begin
                        state_reg <= S_COMMIT;
                    end
                end
                S_WAKE: begin
                    if (live_reg[idx_reg] && reason_reg[idx_reg] == wake_reason
                        && object_reg[idx_reg] == wake_obj) begin
                        reason_reg[idx_reg] <= rrps_pkg::R_RUN;
                    end
                    if (idx_reg == LAST) begin
                        if (mode == rrps_pkg::MODE_EXIT && live_total_reg >= CW'(2)) begin
                            idx_reg   <= cur_inc;
                            state_reg <= S_PICK;
                        end else begin
                            state_reg <= S_FIN;
                        end
                    end else begin
                        idx_reg <= idx_inc;
                    end
                end
                S_COMMIT: begin
                    // Commit the search result.
                    state_reg <= S_FIN;
                    if (mode == rrps_pkg::MODE_EXIT) begin
                        reason_reg[cur_reg]   <= rrps_pkg::R_RUN;
                        live_reg[cur_reg]     <= 1'b0;
                        object_reg[cur_reg]   <= '0;
                        deadline_reg[cur_reg] <= '0;
                        live_total_reg <= live_total_reg - CW'(1);
                        if (found_reg) begin
                            cur_reg <= nxt_reg;
                            reason_reg[nxt_reg] <= rrps_pkg::R_RUN;
                        end
                        sw_reg <= 1'b1;
                    end else if (found_reg && nxt_reg != cur_reg) begin
                        cur_reg <= nxt_reg;
                        sw_reg  <= 1'b1;
                    end else if (mode != rrps_pkg::MODE_DISPATCH) begin
                        reason_reg[cur_reg] <= rrps_pkg::R_RUN;
                    end
                end
                S_FIN: begin
                    m_tdata_reg <= {5'd0,
                        (slice_reg == 16'd0) ? 16'd1 : slice_reg,
                        (depth_reg != 8'd0),
                        3'(live_total_reg),
                        2'(new_reg),
                        sw_reg,
                        2'(cur_reg),
                        status_reg};
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    if (m_tready) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    property p_one_side;
        @(posedge aclk) disable iff (!aresetn) !(s_tready && m_tvalid);
    endproperty
    a_one_side: assert property (p_one_side) else $error("ready while result pending");

    property p_live_nonzero;
        @(posedge aclk) disable iff (!aresetn) live_total_reg != '0;
    endproperty
    a_live_nonzero: assert property (p_live_nonzero) else $error("no live slot");

    property p_cur_live;
        @(posedge aclk) disable iff (!aresetn) s_tready |-> live_reg[cur_reg];
    endproperty
    a_cur_live: assert property (p_cur_live) else $error("running slot not live");
endmodule
`default_nettype wire
